// ===== design/skin_pixel_column_centroid_core_assert.svh =====
// assertion macros used by the checker file of the skin pixel centroid core
`ifndef SKIN_PIXEL_COLUMN_CENTROID_CORE_ASSERT_SVH
`define SKIN_PIXEL_COLUMN_CENTROID_CORE_ASSERT_SVH

// same-cycle implication, inactive during reset
`define SPCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, inactive during reset
`define SPCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also covers the reset cycles
`define SPCC_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/spcc_pkg.sv =====
// shared types and constants of the skin pixel column centroid core
package spcc_pkg;

    localparam int COLUMN_BITS = 11;
    localparam int COUNT_BITS  = 20;
    localparam int SUM_BITS    = COUNT_BITS + COLUMN_BITS;
    localparam int CFG_BITS    = COUNT_BITS;
    localparam int CFG_IDX_BITS = 3;

    localparam int S_DATA_BITS = ((3 * 8 + 1 + COLUMN_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((1 + COLUMN_BITS + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam int DIV_STEP_BITS = $clog2(SUM_BITS + 1);

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LUMA_MIN      = 3'd0,
        REG_LUMA_MAX      = 3'd1,
        REG_RED_DIFF_MIN  = 3'd2,
        REG_RED_DIFF_MAX  = 3'd3,
        REG_BLUE_DIFF_MIN = 3'd4,
        REG_BLUE_DIFF_MAX = 3'd5,
        REG_MIN_SKIN      = 3'd6
    } spcc_reg_t;

    // register reset values
    localparam logic [7:0]            LUMA_MIN_RST      = 8'd0;
    localparam logic [7:0]            LUMA_MAX_RST      = 8'd255;
    localparam logic [7:0]            RED_DIFF_MIN_RST  = 8'd133;
    localparam logic [7:0]            RED_DIFF_MAX_RST  = 8'd173;
    localparam logic [7:0]            BLUE_DIFF_MIN_RST = 8'd77;
    localparam logic [7:0]            BLUE_DIFF_MAX_RST = 8'd127;
    localparam logic [COUNT_BITS-1:0] MIN_SKIN_RST      = COUNT_BITS'(5);

    typedef struct packed {
        logic [7:0] luma_min;
        logic [7:0] luma_max;
        logic [7:0] red_diff_min;
        logic [7:0] red_diff_max;
        logic [7:0] blue_diff_min;
        logic [7:0] blue_diff_max;
    } spcc_bounds_t;

    // one classified pixel on its way from front to back
    typedef struct packed {
        logic                   skin;
        logic [COLUMN_BITS-1:0] column;
        logic                   last;
    } spcc_item_t;

    typedef enum logic {
        ST_ACCUM,
        ST_DIVIDE
    } spcc_state_t;

endpackage

// ===== design/spcc_front.sv =====
// front end: pixel intake, ycrcb conversion and skin classification
module spcc_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spcc_pkg::S_DATA_BITS-1:0] s_tdata,
    input  logic                          s_tlast,
    input  spcc_pkg::spcc_bounds_t        bounds,
    input  logic                          q_full,
    output logic                          q_push,
    output spcc_pkg::spcc_item_t          q_item
);
    import spcc_pkg::*;

    localparam logic [21:0]        LUMA_R_W   = 22'd4899;
    localparam logic [21:0]        LUMA_G_W   = 22'd9617;
    localparam logic [21:0]        LUMA_B_W   = 22'd1868;
    localparam logic [21:0]        ROUND_HALF = 22'd8192;
    localparam logic signed [24:0] CR_W       = 25'sd11682;
    localparam logic signed [24:0] CB_W       = 25'sd9241;
    localparam logic signed [24:0] CHROMA_OFS = 25'sd2105344;

    // (chan - luma) * weight + offset, floor-descaled by 2^14, clamped to a byte
    function automatic logic [7:0] chroma(input logic [7:0] chan, input logic [7:0] luma,
                                          input logic signed [24:0] weight);
        logic signed [24:0] diff;
        logic signed [24:0] acc;
        diff = $signed({17'd0, chan}) - $signed({17'd0, luma});
        acc  = diff * weight + CHROMA_OFS;
        if (acc[24]) begin
            chroma = 8'd0;
        end else if (acc[23:22] != 2'b00) begin
            chroma = 8'd255;
        end else begin
            chroma = acc[21:14];
        end
    endfunction

    logic [7:0]             in_blue, in_green, in_red;
    logic                   in_mask;
    logic [COLUMN_BITS-1:0] in_column;
    logic [21:0]            luma_acc;

    logic                   a_valid_reg, a_valid_next;
    logic [7:0]             blue_reg, red_reg, luma_reg;
    logic                   mask_reg, last_reg;
    logic [COLUMN_BITS-1:0] column_reg;

    logic [7:0] cr, cb;
    logic       skin;

    assign in_blue   = s_tdata[7:0];
    assign in_green  = s_tdata[15:8];
    assign in_red    = s_tdata[23:16];
    assign in_mask   = s_tdata[24];
    assign in_column = s_tdata[25 +: COLUMN_BITS];

    assign luma_acc = LUMA_R_W * 22'(in_red) + LUMA_G_W * 22'(in_green)
                    + LUMA_B_W * 22'(in_blue) + ROUND_HALF;

    // stage register frees once its pixel moves into the queue
    assign s_tready = !a_valid_reg || !q_full;
    assign q_push   = a_valid_reg && !q_full;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_tready) begin
            a_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            blue_reg   <= in_blue;
            red_reg    <= in_red;
            luma_reg   <= luma_acc[21:14];
            mask_reg   <= in_mask;
            column_reg <= in_column;
            last_reg   <= s_tlast;
        end
    end

    assign cr = chroma(red_reg, luma_reg, CR_W);
    assign cb = chroma(blue_reg, luma_reg, CB_W);

    assign skin = mask_reg
               && (luma_reg >= bounds.luma_min) && (luma_reg <= bounds.luma_max)
               && (cr >= bounds.red_diff_min) && (cr <= bounds.red_diff_max)
               && (cb >= bounds.blue_diff_min) && (cb <= bounds.blue_diff_max);

    assign q_item.skin   = skin;
    assign q_item.column = column_reg;
    assign q_item.last   = last_reg;

endmodule

// ===== design/spcc_queue.sv =====
// small fifo of classified pixels between front and back
module spcc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  spcc_pkg::spcc_item_t push_item,
    input  logic                 pop,
    output spcc_pkg::spcc_item_t head_item,
    output logic                 full,
    output logic                 empty
);
    import spcc_pkg::*;

    spcc_item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]     fill_reg, fill_next;

    assign full      = (fill_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty     = (fill_reg == '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/spcc_back.sv =====
// back end: saturating accumulation, serial mean division and result register
module spcc_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_empty,
    input  spcc_pkg::spcc_item_t            q_item,
    output logic                            q_pop,
    input  logic [spcc_pkg::COUNT_BITS-1:0] min_skin_pixels,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_touched,
    output logic [spcc_pkg::COLUMN_BITS-1:0] out_column
);
    import spcc_pkg::*;

    spcc_state_t              state_reg, state_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [SUM_BITS-1:0]      sum_reg, sum_next;
    logic [SUM_BITS-1:0]      dvd_reg, dvd_next;
    logic [COUNT_BITS-1:0]    dvs_reg, dvs_next;
    logic [COUNT_BITS-1:0]    rem_reg, rem_next;
    logic [COLUMN_BITS-1:0]   quo_reg, quo_next;
    logic [DIV_STEP_BITS-1:0] left_reg, left_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_touched_reg, out_touched_next;
    logic [COLUMN_BITS-1:0]   out_column_reg, out_column_next;

    logic                     slot_free, finish, take_skin, touch;
    logic [COUNT_BITS-1:0]    count_upd;
    logic [SUM_BITS:0]        sum_wide;
    logic [SUM_BITS-1:0]      sum_upd;
    logic [COUNT_BITS:0]      trial;
    logic                     q_bit;

    // control outputs
    always_comb begin
        slot_free = !out_valid_reg || out_ready;
        q_pop     = (state_reg == ST_ACCUM) && !q_empty && (!q_item.last || slot_free);
        finish    = (state_reg == ST_DIVIDE) && (left_reg == '0) && slot_free;
    end

    assign take_skin = q_pop && q_item.skin;
    assign count_upd = (take_skin && !(&count_reg)) ? count_reg + 1'b1 : count_reg;
    assign sum_wide  = {1'b0, sum_reg} + (SUM_BITS+1)'(q_item.column);
    assign sum_upd   = !take_skin ? sum_reg :
                       (sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0]);
    assign touch     = count_upd > min_skin_pixels;

    // one restoring step: bring down the next dividend bit
    assign trial = {rem_reg, dvd_reg[SUM_BITS-1]};
    assign q_bit = trial >= {1'b0, dvs_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM: begin
                if (q_pop && q_item.last && touch) begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (finish) begin
                    state_next = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    always_comb begin
        count_next       = count_reg;
        sum_next         = sum_reg;
        dvd_next         = dvd_reg;
        dvs_next         = dvs_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        left_next        = left_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_touched_next = out_touched_reg;
        out_column_next  = out_column_reg;

        if (q_pop) begin
            if (q_item.last) begin
                count_next = '0;
                sum_next   = '0;
                if (touch) begin
                    dvd_next  = sum_upd;
                    dvs_next  = count_upd;
                    rem_next  = '0;
                    quo_next  = '0;
                    left_next = DIV_STEP_BITS'(SUM_BITS);
                end else begin
                    out_valid_next   = 1'b1;
                    out_touched_next = 1'b0;
                    out_column_next  = '0;
                end
            end else begin
                count_next = count_upd;
                sum_next   = sum_upd;
            end
        end

        if ((state_reg == ST_DIVIDE) && (left_reg != '0)) begin
            rem_next  = q_bit ? COUNT_BITS'(trial - {1'b0, dvs_reg}) : trial[COUNT_BITS-1:0];
            quo_next  = {quo_reg[COLUMN_BITS-2:0], q_bit};
            dvd_next  = {dvd_reg[SUM_BITS-2:0], 1'b0};
            left_next = left_reg - 1'b1;
        end

        if (finish) begin
            out_valid_next   = 1'b1;
            out_touched_next = 1'b1;
            out_column_next  = quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCUM;
            count_reg     <= '0;
            sum_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg         <= dvd_next;
        dvs_reg         <= dvs_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        out_touched_reg <= out_touched_next;
        out_column_reg  <= out_column_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_touched = out_touched_reg;
    assign out_column  = out_column_reg;

endmodule

// ===== design/skin_pixel_column_centroid_core.sv =====
// top level of the skin pixel column centroid core
//
// pixels of a rectangle stream in one per transfer as bgr bytes with a mask bit and
// their column; tlast marks the final pixel. each pixel is converted to ycrcb (bt.601,
// q14 weights) in a registered front end and counts as skin when its mask bit is set
// and y, cr and cb lie within the configured inclusive bounds. a four-entry queue
// feeds the back end, which sums the columns of the skin pixels and counts them (both
// saturate). the final pixel yields one result transfer: touched when the count
// exceeds min_skin_pixels, with the truncated mean column, else zeros. within a
// rectangle the core takes one pixel per clock unless the divider is busy or a stalled
// result holds back the final pixel. when the final pixel touches, the mean comes from
// a one-bit-per-cycle restoring divider that steps once per bit of the 31-bit column
// sum and then hands over the quotient, during which further pixels only fill the
// queue. an untouched result is registered straight from the final pixel, a touched
// one once the divider is done. configuration writes take effect at once and belong
// between rectangles.
module skin_pixel_column_centroid_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input pixel stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // blue[7:0], green[15:8], red[23:16], in_mask[24], column[35:25], zero pad
    input  logic [spcc_pkg::S_DATA_BITS-1:0]  s_tdata,
    input  logic                              s_tlast,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // touched[0], finger_column[11:1], zero pad
    output logic [spcc_pkg::M_DATA_BITS-1:0]  m_tdata,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [spcc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [spcc_pkg::CFG_BITS-1:0]     cfg_wdata
);
    import spcc_pkg::*;

    // bound registers and touch threshold
    spcc_bounds_t          bounds_reg, bounds_next;
    logic [COUNT_BITS-1:0] min_skin_reg, min_skin_next;

    // front to queue, queue to back
    logic       q_push, q_pop, q_full, q_empty;
    spcc_item_t push_item, head_item;

    logic                   res_valid, res_touched;
    logic [COLUMN_BITS-1:0] res_column;

    // register file, unknown indexes fall through untouched
    always_comb begin
        bounds_next   = bounds_reg;
        min_skin_next = min_skin_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_LUMA_MIN:      bounds_next.luma_min      = cfg_wdata[7:0];
                REG_LUMA_MAX:      bounds_next.luma_max      = cfg_wdata[7:0];
                REG_RED_DIFF_MIN:  bounds_next.red_diff_min  = cfg_wdata[7:0];
                REG_RED_DIFF_MAX:  bounds_next.red_diff_max  = cfg_wdata[7:0];
                REG_BLUE_DIFF_MIN: bounds_next.blue_diff_min = cfg_wdata[7:0];
                REG_BLUE_DIFF_MAX: bounds_next.blue_diff_max = cfg_wdata[7:0];
                REG_MIN_SKIN:      min_skin_next             = cfg_wdata[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounds_reg.luma_min      <= LUMA_MIN_RST;
            bounds_reg.luma_max      <= LUMA_MAX_RST;
            bounds_reg.red_diff_min  <= RED_DIFF_MIN_RST;
            bounds_reg.red_diff_max  <= RED_DIFF_MAX_RST;
            bounds_reg.blue_diff_min <= BLUE_DIFF_MIN_RST;
            bounds_reg.blue_diff_max <= BLUE_DIFF_MAX_RST;
            min_skin_reg             <= MIN_SKIN_RST;
        end else begin
            bounds_reg   <= bounds_next;
            min_skin_reg <= min_skin_next;
        end
    end

    // conversion and classification
    spcc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .bounds   (bounds_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // decouples the pixel rate from the divider stalls
    spcc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    // accumulation, mean division and the result register
    spcc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_item          (head_item),
        .q_pop           (q_pop),
        .min_skin_pixels (min_skin_reg),
        .out_valid       (res_valid),
        .out_ready       (m_tready),
        .out_touched     (res_touched),
        .out_column      (res_column)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = M_DATA_BITS'({res_column, res_touched});

endmodule

// ===== design/spcc_checker.sv =====
// port-level checks of the skin pixel column centroid core, bound to the top level
`include "skin_pixel_column_centroid_core_assert.svh"

module spcc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [spcc_pkg::M_DATA_BITS-1:0] m_tdata
);
    import spcc_pkg::*;

    // a stalled result keeps its value
    `SPCC_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // no touch means a zero column
    `SPCC_ASSERT_NOW(a_untouched_zero, m_tvalid && !m_tdata[0], m_tdata[COLUMN_BITS:1] == '0, "column set without touch")

    // reset leaves no result pending and the input open
    `SPCC_ASSERT_RESET(a_reset_clear, !aresetn, !m_tvalid && s_tready, "state survived reset")

endmodule

bind skin_pixel_column_centroid_core spcc_checker u_spcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
